// File: rtl/core/color_key_boundary_extract_core_defines.svh
// assertion helpers used by the core file
`ifndef COLOR_KEY_BOUNDARY_EXTRACT_CORE_DEFINES_SVH
`define COLOR_KEY_BOUNDARY_EXTRACT_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CKBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CKBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ckbe_pkg.sv
package ckbe_pkg;

  // field and register widths
  localparam int unsigned PIXEL_W      = 32;
  localparam int unsigned CFG_SIDE_W   = 9;
  localparam int unsigned ORIGIN_W     = 12;
  localparam int unsigned COORD_W      = 13;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned OUT_TDATA_W  = 32;

  // default geometry
  localparam int unsigned MAX_SIDE_DEF = 256;

  // saturation point of the output coordinates
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(4349);

  // register reset values
  localparam logic [PIXEL_W-1:0]    KEY_COLOR_RST = '0;
  localparam logic [CFG_SIDE_W-1:0] SIDE_RST      = CFG_SIDE_W'(50);
  localparam logic [ORIGIN_W-1:0]   ORIGIN_RST    = '0;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COLOR     = 3'd0,
    REG_SPRITE_WIDTH  = 3'd1,
    REG_SPRITE_HEIGHT = 3'd2,
    REG_ORIGIN_X      = 3'd3,
    REG_ORIGIN_Y      = 3'd4
  } ckbe_reg_e;

  // neighbour taps reported by one history cell, in post-shift positions
  typedef struct packed {
    logic upper;   // position h+1, pixel above in previous column
    logic centre;  // position h, pixel being judged
    logic lower;   // position h-1, pixel below in previous column
    logic left;    // position 2h, same row two columns back
  } ckbe_tap_t;

endpackage

// File: rtl/core/ckbe_cell.sv
module ckbe_cell
  import ckbe_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF,
  parameter int unsigned IDX      = 0,
  localparam int unsigned SW      = $clog2(MAX_SIDE + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          bit_i,
  input  logic [SW-1:0] side_i,
  output logic          bit_o,
  output ckbe_tap_t     tap_o
);

  localparam int unsigned TW = SW + 2;

  logic          m_q;
  logic [TW-1:0] pos;
  logic [TW-1:0] side_ext;
  logic [TW-1:0] side_dbl;

  // one match bit of the history line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= 1'b0;
    end else if (shift_i) begin
      m_q <= bit_i;
    end
  end

  assign bit_o = m_q;

  // after the shift this bit sits one position further down the line
  assign pos      = TW'(IDX) + TW'(1);
  assign side_ext = TW'(side_i);
  assign side_dbl = TW'(side_i) << 1;

  // report the bit when this cell feeds one of the neighbour taps
  assign tap_o.lower  = m_q && (pos + TW'(1) == side_ext);
  assign tap_o.centre = m_q && (pos == side_ext);
  assign tap_o.upper  = m_q && (pos == side_ext + TW'(1));
  assign tap_o.left   = m_q && (pos == side_dbl);

endmodule

// File: rtl/core/color_key_boundary_extract_core.sv
// Boundary extraction for a color-keyed sprite.
// Input channel s_axis: one pixel word per item in column-major order (x outer,
// y inner); tuser bit 0 marks column 0 row 0 and restarts the scan counters.
// Output channel m_axis: one item per boundary pixel, the x and y coordinates
// plus the sprite origin, saturated at 4349, in scan order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 key
// color, 1 width, 2 height, 3 origin x, 4 origin y); write only while idle.
// Throughput: one pixel per cycle unless a waiting result stalls input. A row of
// 2*MAX_SIDE one-bit cells shifts the match history by one place per accepted
// pixel; cells chosen by the height give the judged pixel and three neighbours,
// the new pixel the fourth. Latency: the verdict for (x,y) is made when pixel
// (x+1,y) is accepted and the item shows on m_axis in the next cycle.
// Reset clears the history cells, scan counters and output valid flag and loads
// the register defaults (50 by 50 sprite, key 0, origin 0).
// A stalled receiver holds the output item; s_axis_tready stays high while the
// output register is empty or being taken, so input stops only when a result
// waits and m_axis_tready is low.
`include "color_key_boundary_extract_core_defines.svh"

module color_key_boundary_extract_core
  import ckbe_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // tdata: pixel_value [31:0]
  input  logic [PIXEL_W-1:0]     s_axis_tdata,
  // tuser: first_pixel [0]
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: boundary_x [12:0], boundary_y [25:13], zero [31:26]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned SW   = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW   = $clog2(MAX_SIDE);
  localparam int unsigned AW   = SW + 1;
  localparam int unsigned XW   = (SW > CFG_SIDE_W) ? SW : CFG_SIDE_W;
  localparam int unsigned HIST = 2 * MAX_SIDE;
  localparam int unsigned SUMW = COORD_W + 1;

  // configuration registers
  logic [PIXEL_W-1:0]    key_color_q;
  logic [CFG_SIDE_W-1:0] sprite_width_q;
  logic [CFG_SIDE_W-1:0] sprite_height_q;
  logic [ORIGIN_W-1:0]   origin_x_q;
  logic [ORIGIN_W-1:0]   origin_y_q;

  // scan state and output register
  logic [CW-1:0]      col_q, col_d;
  logic [CW-1:0]      row_q, row_d;
  logic               out_valid_q;
  logic [COORD_W-1:0] bx_q, bx_d;
  logic [COORD_W-1:0] by_q, by_d;

  logic               in_acc;
  logic               match_new;
  logic [SW-1:0]      w_eff, h_eff;
  logic [XW-1:0]      w_ext, h_ext;
  logic [CW-1:0]      col_cur, row_cur;
  logic [AW-1:0]      col_a, row_a, w_a, h_a, row_nx, col_nx;
  logic               judge, hit;
  logic [SUMW-1:0]    x_sum, y_sum;
  logic               hist_bits [HIST];
  ckbe_tap_t          taps [HIST];
  ckbe_tap_t          tap_any;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign match_new     = (s_axis_tdata == key_color_q);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_color_q     <= KEY_COLOR_RST;
      sprite_width_q  <= SIDE_RST;
      sprite_height_q <= SIDE_RST;
      origin_x_q      <= ORIGIN_RST;
      origin_y_q      <= ORIGIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_COLOR:     key_color_q     <= cfg_data_i[PIXEL_W-1:0];
        REG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data_i[CFG_SIDE_W-1:0];
        REG_SPRITE_HEIGHT: sprite_height_q <= cfg_data_i[CFG_SIDE_W-1:0];
        REG_ORIGIN_X:      origin_x_q      <= cfg_data_i[ORIGIN_W-1:0];
        REG_ORIGIN_Y:      origin_y_q      <= cfg_data_i[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sprite size: clamp to MAX_SIDE, zero counts as one
  assign w_ext = XW'(sprite_width_q);
  assign h_ext = XW'(sprite_height_q);

  always_comb begin
    priority if (w_ext > XW'(MAX_SIDE)) begin
      w_eff = SW'(MAX_SIDE);
    end else if (w_ext == '0) begin
      w_eff = SW'(1);
    end else begin
      w_eff = SW'(w_ext);
    end
    priority if (h_ext > XW'(MAX_SIDE)) begin
      h_eff = SW'(MAX_SIDE);
    end else if (h_ext == '0) begin
      h_eff = SW'(1);
    end else begin
      h_eff = SW'(h_ext);
    end
  end

  // history line: cell 0 takes the new match bit, each cell feeds the next
  for (genvar k = 0; k < HIST; k++) begin : g_cell
    logic cell_in;
    if (k == 0) begin : g_head
      assign cell_in = match_new;
    end else begin : g_link
      assign cell_in = hist_bits[k-1];
    end
    ckbe_cell #(
      .MAX_SIDE(MAX_SIDE),
      .IDX     (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(in_acc),
      .bit_i  (cell_in),
      .side_i (h_eff),
      .bit_o  (hist_bits[k]),
      .tap_o  (taps[k])
    );
  end

  // gather the neighbour taps, at most one cell drives each
  always_comb begin
    tap_any = '0;
    for (int i = 0; i < HIST; i++) begin
      tap_any = ckbe_tap_t'(tap_any | taps[i]);
    end
  end

  // position of the current pixel
  assign col_cur = s_axis_tuser ? '0 : col_q;
  assign row_cur = s_axis_tuser ? '0 : row_q;
  assign col_a   = AW'(col_cur);
  assign row_a   = AW'(row_cur);
  assign w_a     = AW'(w_eff);
  assign h_a     = AW'(h_eff);

  // the pixel one column back in this row is judged now
  assign judge = (w_a >= AW'(3)) && (h_a >= AW'(3)) && (col_a >= AW'(2)) &&
                 (col_a < w_a) && (row_a >= AW'(1)) && (row_a + AW'(1) < h_a);
  assign hit   = judge && tap_any.centre &&
                 !(match_new && tap_any.upper && tap_any.lower && tap_any.left);

  // coordinates with origin, saturated
  assign x_sum = SUMW'(col_cur) - SUMW'(1) + SUMW'(origin_x_q);
  assign y_sum = SUMW'(row_cur) + SUMW'(origin_y_q);
  assign bx_d  = (x_sum > SUMW'(COORD_MAX)) ? COORD_MAX : x_sum[COORD_W-1:0];
  assign by_d  = (y_sum > SUMW'(COORD_MAX)) ? COORD_MAX : y_sum[COORD_W-1:0];

  // scan counters advance row first, then column, wrapping at the sprite size
  always_comb begin
    row_nx = row_a + AW'(1);
    col_nx = col_a + AW'(1);
    if (row_nx >= h_a) begin
      row_d = '0;
      col_d = (col_nx >= w_a) ? '0 : col_nx[CW-1:0];
    end else begin
      row_d = row_nx[CW-1:0];
      col_d = col_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= hit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && hit) begin
      bx_q <= bx_d;
      by_q <= by_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({by_q, bx_q});

  // checks
  `CKBE_ASSERT_NOW(a_result_from_pixel, $rose(out_valid_q), $past(in_acc),
    "result appeared without an accepted pixel")
  `CKBE_ASSERT_NOW(a_coord_range, out_valid_q, (bx_q <= COORD_MAX) && (by_q <= COORD_MAX),
    "boundary coordinate beyond saturation point")
  `CKBE_ASSERT_NOW(a_stall_blocks_input, out_valid_q && !m_axis_tready, !s_axis_tready,
    "pixel taken while a result waits")

endmodule

// File: bench/tb_color_key_boundary_extract_core.sv
`timescale 1ns / 100ps

module tb_color_key_boundary_extract_core;
  import ckbe_pkg::*;

  localparam int unsigned HIST_LEN = 2 * MAX_SIDE_DEF + 1;
  localparam int unsigned ITEM_TARGET = 1900;
  localparam int unsigned CALM_AFTER = 1600;
  localparam int unsigned HOLD_CYCLES = 400;
  // first index past the defined registers
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_BASE = CFG_IDX_W'(REG_ORIGIN_Y + 1);

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic               first;
  } pixel_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } boundary_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [PIXEL_W-1:0]     s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  pixel_item_t pixel_feed[$];
  boundary_t   boundary_due[$];
  int unsigned items_sent = 0;
  int unsigned fault_count = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  logic        calm = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_off = 1'b0;

  // predictor copy of the registers and scan state
  logic [PIXEL_W-1:0]    key_r;
  logic [CFG_SIDE_W-1:0] width_r;
  logic [CFG_SIDE_W-1:0] height_r;
  logic [ORIGIN_W-1:0]   origin_x_r;
  logic [ORIGIN_W-1:0]   origin_y_r;
  logic [HIST_LEN-1:0]   match_hist;
  int unsigned           scan_col;
  int unsigned           scan_row;

  color_key_boundary_extract_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // side length the scan really uses
  function automatic int unsigned side_used(input logic [CFG_SIDE_W-1:0] v);
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    if (v == 0) return 1;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] clip_coord(input int unsigned v);
    if (v > COORD_MAX) return COORD_MAX;
    return COORD_W'(v);
  endfunction

  // keep the low bits, fill the rest of the write word with noise
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input int unsigned bits);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << bits) - 1;
    return (v & mask) | ($urandom & ~mask);
  endfunction

  // shift in one match bit and judge the pixel to the left of it
  task automatic predict_boundary(input logic [PIXEL_W-1:0] pix, input logic first);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    logic        centre;
    logic        all_in;
    boundary_t   hit;
    w = side_used(width_r);
    h = side_used(height_r);
    if (first) begin
      scan_col = 0;
      scan_row = 0;
    end
    col = scan_col;
    row = scan_row;
    match_hist = {match_hist[HIST_LEN-2:0], pix == key_r};
    if (w >= 3 && h >= 3 && col >= 2 && col < w && row >= 1 && row + 1 < h) begin
      centre = match_hist[h];
      all_in = match_hist[0] & match_hist[h-1] & match_hist[h+1] & match_hist[2*h];
      if (centre && !all_in) begin
        hit.x = clip_coord(col - 1 + origin_x_r);
        hit.y = clip_coord(row + origin_y_r);
        boundary_due = {boundary_due, hit};
      end
    end
    row = row + 1;
    if (row >= h) begin
      row = 0;
      col = col + 1;
      if (col >= w) col = 0;
    end
    scan_col = col;
    scan_row = row;
  endtask

  // predictor: register writes and accepted pixels
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      key_r      = KEY_COLOR_RST;
      width_r    = SIDE_RST;
      height_r   = SIDE_RST;
      origin_x_r = ORIGIN_RST;
      origin_y_r = ORIGIN_RST;
      match_hist = '0;
      scan_col   = 0;
      scan_row   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_COLOR:     key_r      = cfg_data_i[PIXEL_W-1:0];
          REG_SPRITE_WIDTH:  width_r    = cfg_data_i[CFG_SIDE_W-1:0];
          REG_SPRITE_HEIGHT: height_r   = cfg_data_i[CFG_SIDE_W-1:0];
          REG_ORIGIN_X:      origin_x_r = cfg_data_i[ORIGIN_W-1:0];
          REG_ORIGIN_Y:      origin_y_r = cfg_data_i[ORIGIN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_boundary(s_axis_tdata, s_axis_tuser);
    end
  end

  // pixel driver with random gaps
  always @(posedge clk_i) begin : pixel_drv
    pixel_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_feed.size() > 0) begin
        nxt = pixel_feed.pop_front();
        s_axis_tdata  <= nxt.value;
        s_axis_tuser  <= nxt.first;
        s_axis_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready with random stalls and the long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_gap = 0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) take_gap = $urandom_range(1, 12);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // compare each boundary item with the oldest prediction
  always @(posedge clk_i) begin : boundary_chk
    boundary_t seen;
    boundary_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.x = m_axis_tdata[COORD_W-1:0];
      seen.y = m_axis_tdata[2*COORD_W-1:COORD_W];
      if (boundary_due.size() == 0) begin
        $error("unexpected boundary item x=%0d y=%0d", seen.x, seen.y);
        fault_count++;
      end else begin
        want = boundary_due.pop_front();
        if (seen.x !== want.x) begin
          $error("boundary_x expected %0d actual %0d", want.x, seen.x);
          fault_count++;
        end
        if (seen.y !== want.y) begin
          $error("boundary_y expected %0d actual %0d", want.y, seen.y);
          fault_count++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:2*COORD_W] !== '0) begin
          $error("tdata padding expected 0 actual %0h",
                 m_axis_tdata[OUT_TDATA_W-1:2*COORD_W]);
          fault_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait for all pixels taken and all boundary items seen
  task automatic settle_block();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    while (pixel_feed.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (boundary_due.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    if (boundary_due.size() != 0) begin
      $error("%0d boundary items never arrived", boundary_due.size());
      fault_count++;
      boundary_due.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  // queue pixels: key, near misses of the key and random words
  task automatic feed_pixels(input int unsigned count, input int unsigned density,
                             input logic [PIXEL_W-1:0] key, input logic lead_first,
                             input bit restarts);
    pixel_item_t it;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < density) it.value = key;
      else if ($urandom_range(0, 1) != 0) it.value = $urandom;
      else it.value = key ^ (32'h1 << $urandom_range(0, 31));
      if (i == 0) it.first = lead_first;
      else it.first = restarts && ($urandom_range(0, 199) == 0);
      pixel_feed = {pixel_feed, it};
      items_sent++;
    end
  endtask

  function automatic logic [PIXEL_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ORIGIN_W-1:0] pick_origin();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return ORIGIN_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [CFG_SIDE_W-1:0] pick_side();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return CFG_SIDE_W'($urandom_range(0, 2));
    if (r == 1) return CFG_SIDE_W'($urandom_range(9, 16));
    return CFG_SIDE_W'($urandom_range(3, 7));
  endfunction

  initial begin
    pixel_item_t           it;
    logic [PIXEL_W-1:0]    key_now;
    logic [CFG_SIDE_W-1:0] w_set;
    logic [CFG_SIDE_W-1:0] h_set;
    int unsigned           w_eff;
    int unsigned           h_eff;
    int unsigned           phase;
    int unsigned           density;
    int unsigned           frames;
    logic                  lead;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 sprite, all-ones key, gap on the top border next to the centre
    key_now = '1;
    w_set = 3;
    h_set = 3;
    write_reg(REG_KEY_COLOR, key_now);
    write_reg(REG_SPRITE_WIDTH, w_set);
    write_reg(REG_SPRITE_HEIGHT, h_set);
    write_reg(REG_ORIGIN_X, '0);
    write_reg(REG_ORIGIN_Y, '0);
    write_reg(CFG_IDX_W'(REG_SPARE_BASE + $urandom_range(0, 2)), $urandom);
    for (int unsigned i = 0; i < 9; i++) begin
      it.value = (i == 3) ? '0 : key_now;
      it.first = (i == 0);
      pixel_feed = {pixel_feed, it};
      items_sent++;
    end
    settle_block();

    // wrap into a second frame with no first flag, largest origins, near miss
    write_reg(REG_ORIGIN_X, with_junk(12'hFFF, ORIGIN_W));
    write_reg(REG_ORIGIN_Y, with_junk(12'hFFF, ORIGIN_W));
    for (int unsigned i = 0; i < 9; i++) begin
      it.value = (i == 7) ? ~PIXEL_W'(1) : key_now;
      it.first = 1'b0;
      pixel_feed = {pixel_feed, it};
      items_sent++;
    end
    settle_block();

    // zero width and short height: no interior, nothing comes out
    key_now = '0;
    w_set = 0;
    h_set = 2;
    write_reg(REG_KEY_COLOR, key_now);
    write_reg(REG_SPRITE_WIDTH, w_set);
    write_reg(REG_SPRITE_HEIGHT, h_set);
    for (int unsigned i = 0; i < 6; i++) begin
      it.value = '0;
      it.first = (i == 0);
      pixel_feed = {pixel_feed, it};
      items_sent++;
    end
    settle_block();

    // random phases
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      if (items_sent > CALM_AFTER) calm <= 1'b1;
      if (phase == 4) begin
        // oversized width with one-row scan, then grow the height mid-frame
        key_now = pick_key();
        w_set = 300;
        h_set = 1;
        write_reg(REG_KEY_COLOR, key_now);
        write_reg(REG_SPRITE_WIDTH, with_junk(w_set, CFG_SIDE_W));
        write_reg(REG_SPRITE_HEIGHT, h_set);
        write_reg(REG_ORIGIN_X, 12'hFFF);
        feed_pixels(250, 60, key_now, 1'b1, 1'b0);
        settle_block();
        h_set = 3;
        write_reg(REG_SPRITE_HEIGHT, h_set);
        feed_pixels(18, 60, key_now, 1'b0, 1'b0);
        settle_block();
      end else if (phase == 7) begin
        // reach column two, then grow the height past the limit mid-frame
        key_now = pick_key();
        w_set = MAX_SIDE_DEF;
        h_set = 3;
        write_reg(REG_KEY_COLOR, key_now);
        write_reg(REG_SPRITE_WIDTH, w_set);
        write_reg(REG_SPRITE_HEIGHT, h_set);
        write_reg(REG_ORIGIN_X, pick_origin());
        write_reg(REG_ORIGIN_Y, 12'hFFF);
        feed_pixels(6, 60, key_now, 1'b1, 1'b0);
        settle_block();
        h_set = 511;
        write_reg(REG_SPRITE_HEIGHT, with_junk(h_set, CFG_SIDE_W));
        feed_pixels(256, 60, key_now, 1'b0, 1'b0);
        settle_block();
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          key_now = pick_key();
          write_reg(REG_KEY_COLOR, key_now);
        end
        if (phase == 3) begin
          w_set = 6;
          h_set = 6;
          write_reg(REG_SPRITE_WIDTH, w_set);
          write_reg(REG_SPRITE_HEIGHT, h_set);
        end else begin
          if ($urandom_range(0, 1) != 0) begin
            w_set = pick_side();
            write_reg(REG_SPRITE_WIDTH, with_junk(w_set, CFG_SIDE_W));
          end
          if ($urandom_range(0, 1) != 0) begin
            h_set = pick_side();
            write_reg(REG_SPRITE_HEIGHT, with_junk(h_set, CFG_SIDE_W));
          end
        end
        if ($urandom_range(0, 2) == 0) write_reg(REG_ORIGIN_X, with_junk(pick_origin(), ORIGIN_W));
        if ($urandom_range(0, 2) == 0) write_reg(REG_ORIGIN_Y, with_junk(pick_origin(), ORIGIN_W));
        if ($urandom_range(0, 9) == 0) begin
          write_reg(CFG_IDX_W'(REG_SPARE_BASE + $urandom_range(0, 2)), $urandom);
        end
        w_eff = side_used(w_set);
        h_eff = side_used(h_set);
        density = $urandom_range(40, 90);
        frames = $urandom_range(1, 3);
        lead = ($urandom_range(0, 4) != 0);
        // receiver holds off while whole frames keep coming
        if (phase == 3) begin
          hold_go = 1'b1;
          density = 60;
          frames = 3;
          lead = 1'b1;
        end
        for (int unsigned f = 0; f < frames; f++) begin
          feed_pixels(w_eff * h_eff, density, key_now, (f == 0) ? lead : 1'b1, 1'b1);
        end
        // a cut-off frame leaves the scan mid-frame for the next setting
        if ($urandom_range(0, 2) == 0) begin
          feed_pixels($urandom_range(1, w_eff * h_eff), density, key_now, 1'b1, 1'b1);
        end
        settle_block();
      end
    end

    settle_block();
    if (fault_count == 0) begin
      $display("color_key_boundary_extract_core verification clean");
    end else begin
      $display("color_key_boundary_extract_core verification failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("color_key_boundary_extract_core verification failed");
    $finish;
  end

endmodule
